### rtl/multichannel_iir_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Multichannel IIR filter core - assertion macros
// Shared concurrent assertion shorthands for the filter core.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_IIR_FILTER_CORE_DEFINES_SVH
`define MULTICHANNEL_IIR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCIIR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCIIR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mciir_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel IIR filter package
// Fixed field widths, accumulator size and the control bundle for the MAC.
// ----------------------------------------------------------------------------
`default_nettype none

package mciir_pkg;

    // Fixed widths of the stream fields and the order register.
    localparam int CHAN_W      = 3;
    localparam int CIDX_W      = 6;
    localparam int ORDER_REG_W = 5;

    // Order register value after reset.
    localparam logic [ORDER_REG_W-1:0] ORDER_RESET = 5'd8;

    // Accumulator width; sums wrap modulo 2^ACC_W.
    localparam int ACC_W = 64;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clr;  // start a new sum
        logic en;   // operands are valid this cycle
    } t_mac_ctrl;

endpackage

`default_nettype wire

### rtl/mciir_mac.sv
// ----------------------------------------------------------------------------
// Multichannel IIR filter shared MAC
// One registered multiplier feeding a wide wrapping accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mciir_mac #(
    parameter int COEF_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mciir_pkg::t_mac_ctrl                 i_ctrl,
    input  logic signed [COEF_WIDTH-1:0]         i_coef,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    output logic signed [mciir_pkg::ACC_W-1:0]   o_acc
);
    import mciir_pkg::*;

    logic signed [ACC_W-1:0] r_prod;
    logic                    r_pvld;
    logic signed [ACC_W-1:0] r_acc;

    // Product stage qualifier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctrl.en && !i_ctrl.clr;
        end
    end

    // Registered product, added to the accumulator in the following cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= ACC_W'(i_coef * i_sample);
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### rtl/multichannel_iir_filter_core.sv
// ----------------------------------------------------------------------------
// Multichannel IIR filter core
// Direct-form-I IIR filter with one coefficient set shared by all channels.
// ----------------------------------------------------------------------------
// A sample transfer (tuser low) filters one sample of one channel and gives
// one result transfer; a coefficient transfer (tuser high) loads at most one
// tap and gives no result. The order used for a sample is the filter_order
// register clamped to MAX_ORDER. Every feedforward and feedback product goes
// through the single shared multiplier, one product per cycle, and the
// history rings are read from one port per cycle. The input side is not ready
// until the sample is done, and the final step also waits for the previous
// result to leave the output register. Writing filter_order restarts every
// channel with empty history.
`default_nettype none

module multichannel_iir_filter_core #(
    parameter int MAX_ORDER    = 16,
    parameter int CHANNELS     = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32,
    localparam int IN_BITS     = mciir_pkg::CHAN_W + SAMPLE_WIDTH + mciir_pkg::CIDX_W
                                 + COEF_WIDTH,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = mciir_pkg::CHAN_W + SAMPLE_WIDTH,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [IN_TDATA_W-1:0]               i_s_tdata,  // channel, sample_in, coef_index, coef_value
    input  logic                                i_s_tuser,  // req_type
    // Result stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [OUT_TDATA_W-1:0]              o_m_tdata,  // out_channel, sample_out
    // Order register write.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mciir_pkg::ORDER_REG_W-1:0]   i_cfg_data
);
    import mciir_pkg::*;
    `include "multichannel_iir_filter_core_defines.svh"

    localparam int RING_LEN   = MAX_ORDER + 1;
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);
    localparam int HIST_DEPTH = CHANNELS * RING_LEN;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int CI_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COEF_FRAC  = COEF_WIDTH - 8;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO     = -SAT_HI - 1;
    localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX    = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN    = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP0,
        S_TAPS,
        S_DRAIN,
        S_ROUND,
        S_SAT
    } t_state;

    // Input field unpacking.
    logic [CHAN_W-1:0]              in_ch;
    logic signed [SAMPLE_WIDTH-1:0] in_smp;
    logic [CIDX_W-1:0]              in_cidx;
    logic signed [COEF_WIDTH-1:0]   in_coef;

    assign in_ch   = i_s_tdata[CHAN_W-1:0];
    assign in_smp  = i_s_tdata[CHAN_W +: SAMPLE_WIDTH];
    assign in_cidx = i_s_tdata[CHAN_W + SAMPLE_WIDTH +: CIDX_W];
    assign in_coef = i_s_tdata[CHAN_W + SAMPLE_WIDTH + CIDX_W +: COEF_WIDTH];

    // Configuration and coefficient state.
    logic [ORDER_REG_W-1:0]       r_order_reg;
    logic signed [COEF_WIDTH-1:0] r_ff [RING_LEN];
    logic signed [COEF_WIDTH-1:0] r_fb [RING_LEN];
    logic [ORD_W-1:0]             r_ring_pos [CHANNELS];
    logic [HIST_DEPTH-1:0]        r_hvalid;

    // History memories and their read registers.
    logic [SAMPLE_WIDTH-1:0]        mem_x [HIST_DEPTH];
    logic [SAMPLE_WIDTH-1:0]        mem_y [HIST_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_xh;
    logic signed [SAMPLE_WIDTH-1:0] r_yh;
    logic                           r_hv;

    // Sequencer state.
    t_state                         r_state;
    logic [CHAN_W-1:0]              r_ch;
    logic signed [SAMPLE_WIDTH-1:0] r_x0;
    logic [ORD_W-1:0]               r_ord;
    logic [ORD_W-1:0]               r_pos;
    logic [ORD_W-1:0]               r_j;
    logic [HA_W-1:0]                r_base;
    logic [ORD_W-1:0]               r_tap;
    logic                           r_sub;
    logic signed [ACC_W-1:0]        r_rnd;
    logic                           r_m_tvalid;
    logic [OUT_TDATA_W-1:0]         r_m_data;

    // Handshakes.
    logic s_fire;
    logic cfg_fire;
    logic slot_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign slot_free   = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_data;

    // Per-sample setup values taken at the input transfer.
    logic [CI_W-1:0]  in_ch_idx;
    logic             in_ch_ok;
    logic [ORD_W-1:0] ord_clamp;
    logic [ORD_W-1:0] pos_cur;
    logic [ORD_W-1:0] pos_ok;
    logic [HA_W-1:0]  in_base;

    assign in_ch_idx = CI_W'(in_ch);
    assign in_ch_ok  = (int'(in_ch) < CHANNELS);
    assign ord_clamp = (int'(r_order_reg) > MAX_ORDER) ? ORD_W'(MAX_ORDER)
                                                       : ORD_W'(r_order_reg);
    assign pos_cur   = r_ring_pos[in_ch_idx];
    assign pos_ok    = (pos_cur > ord_clamp) ? '0 : pos_cur;
    assign in_base   = HA_W'(int'(in_ch_idx) * RING_LEN);

    // Ring walk: reads step backward from the newest entry.
    logic [ORD_W-1:0] j_dec;
    logic [ORD_W-1:0] rd_j;
    logic             rd_en;
    logic [HA_W-1:0]  rd_addr;
    logic [ORD_W-1:0] new_pos;
    logic             wr_en;
    logic [HA_W-1:0]  wr_addr;

    assign j_dec   = (r_j == '0) ? r_ord : ORD_W'(r_j - 1'b1);
    assign rd_j    = (r_state == S_TAP0) ? r_j : j_dec;
    assign rd_en   = (r_state == S_TAP0) || ((r_state == S_TAPS) && r_sub);
    assign rd_addr = HA_W'(r_base + HA_W'(rd_j));
    assign new_pos = (r_pos == r_ord) ? '0 : ORD_W'(r_pos + 1'b1);
    assign wr_en   = (r_state == S_SAT) && slot_free;
    assign wr_addr = HA_W'(r_base + HA_W'(new_pos));

    // Round half up, then saturate to the sample range.
    logic signed [ACC_W-1:0]  mac_acc;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic [SAMPLE_WIDTH-1:0]  sat_res;

    assign rnd_sum = mac_acc + ROUND_HALF;

    always_comb begin
        if (r_rnd > SAT_HI) begin
            sat_res = SMP_MAX;
        end else if (r_rnd < SAT_LO) begin
            sat_res = SMP_MIN;
        end else begin
            sat_res = r_rnd[SAMPLE_WIDTH-1:0];
        end
    end

    // Operand selection for the shared multiplier.
    t_mac_ctrl                      mac_ctrl;
    logic signed [COEF_WIDTH-1:0]   mul_coef;
    logic signed [SAMPLE_WIDTH-1:0] mul_smp;

    always_comb begin
        mac_ctrl.clr = s_fire;
        mac_ctrl.en  = (r_state == S_TAP0) || (r_state == S_TAPS);
        if (r_state == S_TAP0) begin
            mul_coef = r_ff[0];
            mul_smp  = r_x0;
        end else if (r_sub) begin
            mul_coef = r_fb[r_tap];
            mul_smp  = r_hv ? r_yh : '0;
        end else begin
            mul_coef = r_ff[r_tap];
            mul_smp  = r_hv ? r_xh : '0;
        end
    end

    mciir_mac #(
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_coef   (mul_coef),
        .i_sample (mul_smp),
        .o_acc    (mac_acc)
    );

    // Order register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_reg <= ORDER_RESET;
        end else if (cfg_fire) begin
            r_order_reg <= i_cfg_data;
        end
    end

    // Coefficient tap decode: feedforward, feedback, or ignored.
    logic             cw_ff;
    logic             cw_fb;
    logic [ORD_W-1:0] cw_ff_slot;
    logic [ORD_W-1:0] cw_fb_slot;

    always_comb begin
        cw_ff      = s_fire && i_s_tuser && (int'(in_cidx) <= MAX_ORDER);
        cw_fb      = s_fire && i_s_tuser && (int'(in_cidx) > MAX_ORDER + 1)
                     && (int'(in_cidx) <= 2 * MAX_ORDER + 1);
        cw_ff_slot = ORD_W'(in_cidx);
        cw_fb_slot = ORD_W'(in_cidx - CIDX_W'(MAX_ORDER + 1));
    end

    // Coefficient tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RING_LEN; k++) begin
                r_ff[k] <= '0;
                r_fb[k] <= '0;
            end
        end else begin
            if (cw_ff) begin
                r_ff[cw_ff_slot] <= in_coef;
            end
            if (cw_fb) begin
                r_fb[cw_fb_slot] <= in_coef;
            end
        end
    end

    // Ring positions and history valid bits; an order write restarts all channels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_fire) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_ring_pos[k] <= '0;
            end
            r_hvalid <= '0;
        end else if (wr_en) begin
            r_ring_pos[CI_W'(r_ch)] <= new_pos;
            r_hvalid[wr_addr]       <= 1'b1;
        end
    end

    // History memories: one write at the end of a sample, one read per tap.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= r_x0;
            mem_y[wr_addr] <= sat_res;
        end
        if (rd_en) begin
            r_xh <= mem_x[rd_addr];
            r_yh <= mem_y[rd_addr];
            r_hv <= r_hvalid[rd_addr];
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tap      <= '0;
            r_sub      <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            // The final step loads the next result itself, so it is not cleared there.
            if (r_m_tvalid && i_m_tready && (r_state != S_SAT)) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_fire && !i_s_tuser && in_ch_ok) begin
                        r_ch    <= in_ch;
                        r_x0    <= in_smp;
                        r_ord   <= ord_clamp;
                        r_pos   <= pos_ok;
                        r_j     <= pos_ok;
                        r_base  <= in_base;
                        r_tap   <= ORD_W'(1);
                        r_sub   <= 1'b0;
                        r_state <= S_TAP0;
                    end
                end
                S_TAP0: begin
                    r_state <= (r_ord == '0) ? S_DRAIN : S_TAPS;
                end
                S_TAPS: begin
                    if (!r_sub) begin
                        r_sub <= 1'b1;
                    end else begin
                        r_sub <= 1'b0;
                        r_j   <= j_dec;
                        if (r_tap == r_ord) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_tap <= ORD_W'(r_tap + 1'b1);
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_rnd   <= rnd_sum >>> COEF_FRAC;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (slot_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_data   <= OUT_TDATA_W'({sat_res, r_ch});
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Assertions.
    `MCIIR_ASSERT_IMP(a_tap_in_range, i_clk, i_rst_n, r_state == S_TAPS, (r_tap != '0) && (r_tap <= r_ord), "tap counter outside the active order")
    `MCIIR_ASSERT_IMP(a_ring_in_range, i_clk, i_rst_n, r_state != S_IDLE, (r_pos <= r_ord) && (r_j <= r_ord), "ring index beyond the ring length")
    `MCIIR_ASSERT_NXT(a_coef_write_idle, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tuser, r_state == S_IDLE, "coefficient transfer started a filter pass")
    `MCIIR_ASSERT_IMP(a_result_from_sat, i_clk, i_rst_n, $rose(r_m_tvalid), $past(r_state) == S_SAT, "result raised outside the final step")

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// Multichannel IIR filter core testbench
// Sends sample and coefficient transfers to the filter core over several
// filter_order settings and compares every filtered sample with a predicted
// value. The predictor keeps its own taps, per-channel history rings and
// order register. Both stream sides idle at random, except in the last two phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mciir_pkg::*;

    localparam int MAX_ORDER   = 16;
    localparam int CHANNELS    = 8;
    localparam int NUM_TAPS    = MAX_ORDER + 1;
    localparam int FB_BASE     = MAX_ORDER + 1;      // feedback tap 0, unused
    localparam int LAST_TAP    = 2 * MAX_ORDER + 1;
    localparam int COEF_FRAC   = 24;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (COEF_FRAC - 1);
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
    localparam int unsigned FF_SPAN = 32'h0040_0000;  // +/- 0.25 in Q8.24
    localparam int unsigned FB_SPAN = 32'h0010_0000;  // +/- 1/16 in Q8.24
    localparam int SETTLE_CYCLES    = 2 * MAX_ORDER + 20;
    localparam int NUM_PHASES       = 8;
    localparam int RANDOM_PER_PHASE = 210;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_COEF   = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind          kind;
        logic [2:0]         channel;
        logic signed [15:0] sample_in;
        logic [5:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_filter_req;

    typedef struct {
        logic [2:0]         channel;
        logic signed [15:0] sample;
    } t_filter_res;

    // Predicts filtered samples and checks them in arrival order.
    class t_filter_scoreboard;
        logic signed [31:0] ff_taps[NUM_TAPS];
        logic signed [31:0] fb_taps[NUM_TAPS];
        logic signed [15:0] in_hist[CHANNELS][NUM_TAPS];
        logic signed [15:0] out_hist[CHANNELS][NUM_TAPS];
        int unsigned        ring_pos[CHANNELS];
        int unsigned        order_reg;
        t_filter_res        expected_outputs[$];
        int                 mismatch_count;

        function new();
            foreach (ff_taps[i]) begin
                ff_taps[i] = '0;
                fb_taps[i] = '0;
            end
            restart_channels();
            order_reg      = 32'(ORDER_RESET);
            mismatch_count = 0;
        endfunction

        function void restart_channels();
            foreach (in_hist[c, i]) begin
                in_hist[c][i]  = '0;
                out_hist[c][i] = '0;
            end
            foreach (ring_pos[c])
                ring_pos[c] = 0;
        endfunction

        // An order write restarts every channel with empty history.
        function void set_order(logic [ORDER_REG_W-1:0] value);
            order_reg = 32'(value);
            restart_channels();
        endfunction

        function void note_request(t_filter_req req);
            logic signed [63:0] acc;
            logic signed [63:0] rounded;
            logic signed [15:0] y;
            int unsigned        taps_used, ring_len, pos, j, i;
            t_filter_res        res;

            // Coefficient loads; feedback tap 0 and indexes past the table are dropped.
            if (req.kind == REQ_COEF) begin
                if (req.coef_index <= MAX_ORDER) begin
                    ff_taps[req.coef_index] = req.coef_value;
                end else if (req.coef_index > FB_BASE && req.coef_index <= LAST_TAP) begin
                    fb_taps[req.coef_index - FB_BASE] = req.coef_value;
                end
                return;
            end

            taps_used = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
            ring_len  = taps_used + 1;
            pos       = ring_pos[req.channel];
            if (pos >= ring_len)
                pos = 0;

            // Feedforward over the newest inputs, then feedback over past outputs.
            acc = $signed(ff_taps[0]) * $signed(req.sample_in);
            j = pos;
            for (i = 1; i <= taps_used; i++) begin
                acc = acc + $signed(ff_taps[i]) * $signed(in_hist[req.channel][j]);
                j = (j == 0) ? ring_len - 1 : j - 1;
            end
            j = pos;
            for (i = 1; i <= taps_used; i++) begin
                acc = acc + $signed(fb_taps[i]) * $signed(out_hist[req.channel][j]);
                j = (j == 0) ? ring_len - 1 : j - 1;
            end

            // Round half up to Q1.15, then saturate.
            rounded = (acc + ROUND_HALF) >>> COEF_FRAC;
            if (rounded > 64'sd32767)
                y = SAMPLE_MAX;
            else if (rounded < -64'sd32768)
                y = SAMPLE_MIN;
            else
                y = rounded[15:0];

            pos = (pos + 1 >= ring_len) ? 0 : pos + 1;
            ring_pos[req.channel]      = pos;
            in_hist[req.channel][pos]  = req.sample_in;
            out_hist[req.channel][pos] = y;

            res.channel = req.channel;
            res.sample  = y;
            expected_outputs.push_back(res);
        endfunction

        function void check_result(t_filter_res got);
            t_filter_res want;

            if (expected_outputs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: ch %0d sample %0d", got.channel, got.sample);
                return;
            end
            want = expected_outputs.pop_front();
            if (got.channel !== want.channel || got.sample !== want.sample) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                             want.channel, want.sample, got.channel, got.sample);
            end
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [63:0]            i_s_tdata   = '0;  // channel, sample_in, coef_index, coef_value
    logic                   i_s_tuser   = 1'b0;  // req_type
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [23:0]            o_m_tdata;  // out_channel, sample_out
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [ORDER_REG_W-1:0] i_cfg_data  = '0;

    t_filter_scoreboard board;
    int send_idle_pct = 23;
    int recv_idle_pct = 67;

    multichannel_iir_filter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random back-pressure and a check on every transfer.
    always @(posedge i_clk) begin
        t_filter_res got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.channel = o_m_tdata[2:0];
                got.sample  = o_m_tdata[18:3];
                board.check_result(got);
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [31:0] moderate_coef(int unsigned half_span);
        return $signed(32'($urandom_range(0, 2 * half_span))) - $signed(32'(half_span));
    endfunction

    function automatic t_filter_req make_sample(logic [2:0] ch, logic signed [15:0] x);
        t_filter_req req;
        req.kind       = REQ_SAMPLE;
        req.channel    = ch;
        req.sample_in  = x;
        req.coef_index = 6'($urandom);
        req.coef_value = $urandom;
        return req;
    endfunction

    function automatic t_filter_req make_coef(int unsigned idx, logic signed [31:0] value);
        t_filter_req req;
        req.kind       = REQ_COEF;
        req.channel    = 3'($urandom);
        req.sample_in  = 16'($urandom);
        req.coef_index = 6'(idx);
        req.coef_value = value;
        return req;
    endfunction

    // Mostly samples; some tap reloads, mostly with moderate values.
    function automatic t_filter_req random_request();
        t_filter_req req;
        int unsigned roll;
        req  = make_sample(3'($urandom_range(CHANNELS - 1)), 16'($urandom));
        roll = $urandom_range(99);
        if (roll < 12) begin
            req.kind       = REQ_COEF;
            req.coef_index = ($urandom_range(99) < 85) ? 6'($urandom_range(LAST_TAP))
                                                       : 6'($urandom);
            if ($urandom_range(99) < 10)
                req.coef_value = $urandom;
            else if (req.coef_index <= MAX_ORDER)
                req.coef_value = moderate_coef(FF_SPAN);
            else
                req.coef_value = moderate_coef(FB_SPAN);
        end else if (roll < 20) begin
            req.sample_in = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        end else if (roll < 30) begin
            req.sample_in = 16'($signed(32'($urandom_range(0, 512))) - 256);
        end
        return req;
    endfunction

    // One input transfer, with random idle cycles ahead of it.
    task automatic send_request(input t_filter_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req.kind;
        i_s_tdata  <= {7'b0, req.coef_value, req.coef_index, req.sample_in, req.channel};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(req);
    endtask

    // Hold the input side until every predicted result has been taken.
    task automatic drain_results(input int settle);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [ORDER_REG_W-1:0] value);
        drain_results(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_order(value);
    endtask

    initial begin
        int phase_orders[NUM_PHASES] = '{16, 0, 1, 31, 5, 17, 0, 8};
        int phase, tap, n;

        board = new();
        phase_orders[6] = $urandom_range(2, MAX_ORDER - 1);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero taps, saturation both ways, dropped indexes, rounding.
        send_request(make_sample(3'd0, SAMPLE_MAX));
        send_request(make_coef(0, 32'sh7fff_ffff));
        send_request(make_sample(3'd1, SAMPLE_MIN));
        send_request(make_sample(3'd2, SAMPLE_MAX));
        send_request(make_coef(FB_BASE, 32'sh1234_5678));
        send_request(make_coef(63, 32'sh8000_0000));
        send_request(make_coef(LAST_TAP + 1, -32'sd1));
        send_request(make_coef(0, 32'sh0080_0000));
        send_request(make_sample(3'd3, 16'sd1));
        send_request(make_sample(3'd3, -16'sd1));
        send_request(make_coef(MAX_ORDER, 32'sh8000_0000));
        send_request(make_coef(LAST_TAP, 32'sh7fff_ffff));
        send_request(make_coef(FB_BASE + 1, 32'sh0080_0000));
        send_request(make_sample(3'd7, SAMPLE_MAX));
        send_request(make_sample(3'd7, SAMPLE_MIN));

        // Order zero uses only the current sample.
        write_order(5'd0);
        send_request(make_sample(3'd7, 16'sd12345));
        send_request(make_sample(3'd7, SAMPLE_MIN));

        // Orders above the maximum are clamped.
        write_order(5'd31);
        repeat (3) send_request(make_sample(3'd5, 16'sd1000));

        write_order(5'd1);
        send_request(make_sample(3'd4, SAMPLE_MAX));
        send_request(make_sample(3'd4, SAMPLE_MIN));

        // Random phases over several orders and idle patterns.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 23;
            end
            if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_order(ORDER_REG_W'(phase_orders[phase]));
            for (tap = 0; tap <= LAST_TAP; tap++) begin
                if (tap != FB_BASE)
                    send_request(make_coef(tap, (tap <= MAX_ORDER) ? moderate_coef(FF_SPAN)
                                                                   : moderate_coef(FB_SPAN)));
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == RANDOM_PER_PHASE / 2)
                    drain_results(0);
                send_request(random_request());
            end
        end

        drain_results(SETTLE_CYCLES);
        if (board.mismatch_count == 0 && board.expected_outputs.size() == 0) begin
            $display("** multichannel_iir_filter_core: PASSED **");
        end else begin
            $display("** multichannel_iir_filter_core: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("** multichannel_iir_filter_core: FAILED **");
        $finish;
    end

endmodule
